FILE: src/assert_macros.svh
// assertion macros for the rtl; only event_rolling_fifo includes them
// no dependencies; define SYNTH to compile the checks away
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// same-cycle implication, disabled while in reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: src/erf_pkg.sv
// shared constants for the rolling event fifo
// no dependencies
package erf_pkg;

    localparam int WORD_W        = 64;
    localparam int DEPTH_DEFAULT = 64;

endpackage

FILE: src/event_rolling_fifo.sv
// top level of the rolling event fifo: input register, step logic, result register
// uses erf_pkg, erf_mem and assert_macros.svh
//
//   channel   handshake          fields
//   input     start / busy       roll_event, word_in, write_enable, downstream_full
//   result    done (strobe)      word_out, out_valid, roll_echo
//
// one beat per clock: busy stays low, a new beat may start in every cycle
// a result shows on done once its beat has passed the input reg and the result reg
// the read pointer for the next beat is looked up at the end of each step, so the
// registered store read is ready when that beat arrives
// rst_n clears pointers (read 2, write 1), held valid, the delayed roll flag and done;
// the store and the result fields are not cleared
// the receiver cannot stall: each result stands for exactly one cycle
module event_rolling_fifo
    import erf_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              roll_event,
    input  logic [WORD_W-1:0] word_in,
    input  logic              write_enable,
    input  logic              downstream_full,
    output logic              done,
    output logic [WORD_W-1:0] word_out,
    output logic              out_valid,
    output logic              roll_echo
);

`include "assert_macros.svh"

    localparam int PTR_W = $clog2(DEPTH);
    localparam logic [PTR_W-1:0] PTR_ONE  = PTR_W'(1);
    localparam logic [PTR_W-1:0] PTR_TWO  = PTR_W'(2);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_LAST) ? '0 : p + PTR_ONE;
    endfunction

    // input register
    logic              in_vld_reg;
    logic              in_roll_reg;
    logic [WORD_W-1:0] in_word_reg;
    logic              in_wen_reg;
    logic              in_full_reg;

    // block state
    logic [PTR_W-1:0]  rd_ptr_reg,  rd_ptr_next;
    logic [PTR_W-1:0]  wr_ptr_reg,  wr_ptr_next;
    logic [WORD_W-1:0] held_word_reg;
    logic              held_valid_reg;
    logic              roll_dly_reg;

    // result register
    logic              done_reg;
    logic [WORD_W-1:0] word_out_reg;
    logic              out_valid_reg;
    logic              roll_echo_reg;

    logic [WORD_W-1:0] rd_data;
    logic              mem_valid;
    logic              hold;
    logic [WORD_W-1:0] sel_word;
    logic              sel_valid;
    logic [PTR_W-1:0]  wr_base;
    logic              wr_en;

    wire accept = start && !busy;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_roll_reg <= roll_event;
            in_word_reg <= word_in;
            in_wen_reg  <= write_enable;
            in_full_reg <= downstream_full;
        end
    end

    // step logic
    always_comb
    begin
        mem_valid = rd_ptr_reg < wr_ptr_reg;
        hold      = in_full_reg && held_valid_reg && !roll_dly_reg;
        sel_word  = hold ? held_word_reg : rd_data;
        sel_valid = hold ? held_valid_reg : mem_valid;

        priority if (in_roll_reg)
        begin
            rd_ptr_next = PTR_ONE;
        end
        else if (!hold && mem_valid)
        begin
            rd_ptr_next = ptr_inc(rd_ptr_reg);
        end
        else
        begin
            rd_ptr_next = rd_ptr_reg;
        end

        // a roll in the same beat as a write puts the write at entry 1
        wr_base     = in_roll_reg ? PTR_ONE : wr_ptr_reg;
        wr_ptr_next = in_wen_reg ? ptr_inc(wr_base) : wr_base;
        wr_en       = in_vld_reg && in_wen_reg;
    end

    erf_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_base),
        .wr_data (in_word_reg),
        .rd_en   (in_vld_reg),
        .rd_addr (rd_ptr_next),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg     <= PTR_TWO;
            wr_ptr_reg     <= PTR_ONE;
            held_valid_reg <= 1'b0;
            roll_dly_reg   <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            done_reg <= in_vld_reg;
            if (in_vld_reg)
            begin
                rd_ptr_reg     <= rd_ptr_next;
                wr_ptr_reg     <= wr_ptr_next;
                held_valid_reg <= sel_valid;
                roll_dly_reg   <= in_roll_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_vld_reg)
        begin
            if (!hold)
            begin
                held_word_reg <= rd_data;
            end
            word_out_reg  <= sel_valid ? sel_word : '0;
            out_valid_reg <= sel_valid;
            roll_echo_reg <= roll_dly_reg;
        end
    end

    assign done      = done_reg;
    assign word_out  = word_out_reg;
    assign out_valid = out_valid_reg;
    assign roll_echo = roll_echo_reg;

    `ASSERT_NEXT(a_result_follows, clk, rst_n, accept, ##1 done)
    `ASSERT_IMPL(a_invalid_zero, clk, rst_n, done && !out_valid, word_out == '0)
    `ASSERT_IMPL(a_ptr_range, clk, rst_n, 1'b1, rd_ptr_reg <= PTR_LAST && wr_ptr_reg <= PTR_LAST)
    `ASSERT_NEXT(a_roll_restart, clk, rst_n, in_vld_reg && in_roll_reg && !in_wen_reg, rd_ptr_reg == PTR_ONE && wr_ptr_reg == PTR_ONE)

endmodule

FILE: src/erf_mem.sv
// word store of the rolling event fifo: one write port, one registered read port
// read data forwards a write to the same address in the same cycle; uses erf_pkg
module erf_mem
    import erf_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WORD_W-1:0]        wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WORD_W-1:0]        rd_data
);

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_addr))
            begin
                rd_data_reg <= wr_data;
            end
            else
            begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule
